// File: rtl/mlc_pkg.sv
// Shared types, constants and the arctangent table for the mouse-look camera direction core.
package mlc_pkg;

  localparam int YAW_FULL    = 92160;
  localparam int YAW_HALF    = 46080;
  localparam int QUARTER     = 23040;
  localparam int CORDIC_GAIN = 652032874;

  localparam logic [15:0] SENSITIVITY_RESET = 16'd3277;
  localparam logic [14:0] PITCH_LIMIT_RESET = 15'd22784;

  localparam logic CFG_SENSITIVITY = 1'b0;
  localparam logic CFG_PITCH_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_X,
    S_MUL_Y,
    S_ANGLE,
    S_WRAP,
    S_INIT_P,
    S_STEP_P,
    S_INIT_Y,
    S_STEP_Y,
    S_PROD_X,
    S_PROD_Z,
    S_OUTPUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_x;
    logic mul_y;
    logic angle;
    logic wrap;
    logic yaw_commit;
    logic init_pitch;
    logic init_yaw;
    logic step;
    logic save_pitch;
    logic prod_x;
    logic prod_z;
    logic out_load;
  } cmd_t;

  function automatic logic [25:0] atan_entry(input logic [4:0] idx);
    logic [25:0] v;
    case (idx)
      5'd0:    v = 26'd47185920;
      5'd1:    v = 26'd27855475;
      5'd2:    v = 26'd14718068;
      5'd3:    v = 26'd7471121;
      5'd4:    v = 26'd3750058;
      5'd5:    v = 26'd1876857;
      5'd6:    v = 26'd938658;
      5'd7:    v = 26'd469357;
      5'd8:    v = 26'd234682;
      5'd9:    v = 26'd117342;
      5'd10:   v = 26'd58671;
      5'd11:   v = 26'd29335;
      5'd12:   v = 26'd14668;
      5'd13:   v = 26'd7334;
      5'd14:   v = 26'd3667;
      5'd15:   v = 26'd1833;
      5'd16:   v = 26'd917;
      5'd17:   v = 26'd458;
      5'd18:   v = 26'd229;
      5'd19:   v = 26'd115;
      5'd20:   v = 26'd57;
      5'd21:   v = 26'd29;
      5'd22:   v = 26'd14;
      5'd23:   v = 26'd7;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/mlc_ctrl.sv
// Sequencing state machine for the mouse-look camera direction core.
module mlc_ctrl import mlc_pkg::*; #(
  parameter int COORD_BITS   = 12,
  parameter int CORDIC_STEPS = 16,
  parameter int WRAP_STEPS   = COORD_BITS - 6,
  parameter int WRAP_W       = $clog2(WRAP_STEPS + 1),
  parameter int STEP_W       = $clog2(CORDIC_STEPS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output cmd_t              cmd,
  output logic [WRAP_W-1:0] wrap_k,
  output logic [STEP_W-1:0] step_idx
);

  state_t state;
  state_t state_next;
  logic   out_ready;

  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ANGLE) begin
      wrap_k <= WRAP_W'(WRAP_STEPS - 1);
    end else if (state == S_WRAP) begin
      wrap_k <= wrap_k - 1'b1;
    end
    if (state == S_INIT_P || state == S_INIT_Y) begin
      step_idx <= '0;
    end else if (state == S_STEP_P || state == S_STEP_Y) begin
      step_idx <= step_idx + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_MUL_X;
      S_MUL_X:  state_next = S_MUL_Y;
      S_MUL_Y:  state_next = S_ANGLE;
      S_ANGLE:  state_next = S_WRAP;
      S_WRAP:   if (wrap_k == '0) state_next = S_INIT_P;
      S_INIT_P: state_next = S_STEP_P;
      S_STEP_P: if (step_idx == STEP_W'(CORDIC_STEPS - 1)) state_next = S_INIT_Y;
      S_INIT_Y: state_next = S_STEP_Y;
      S_STEP_Y: if (step_idx == STEP_W'(CORDIC_STEPS - 1)) state_next = S_PROD_X;
      S_PROD_X: state_next = S_PROD_Z;
      S_PROD_Z: state_next = S_OUTPUT;
      S_OUTPUT: if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.load = in_valid;
      S_MUL_X:  cmd.mul_x = 1'b1;
      S_MUL_Y:  cmd.mul_y = 1'b1;
      S_ANGLE:  cmd.angle = 1'b1;
      S_WRAP:   cmd.wrap = 1'b1;
      S_INIT_P: begin
        cmd.init_pitch = 1'b1;
        cmd.yaw_commit = 1'b1;
      end
      S_STEP_P: cmd.step = 1'b1;
      S_INIT_Y: begin
        cmd.init_yaw   = 1'b1;
        cmd.save_pitch = 1'b1;
      end
      S_STEP_Y: cmd.step = 1'b1;
      S_PROD_X: cmd.prod_x = 1'b1;
      S_PROD_Z: cmd.prod_z = 1'b1;
      S_OUTPUT: cmd.out_load = out_ready;
      default:  cmd = '0;
    endcase
  end

endmodule

// File: rtl/mlc_datapath.sv
// Angle accumulation, shared CORDIC unit and output products for the camera direction core.
module mlc_datapath import mlc_pkg::*; #(
  parameter int COORD_BITS   = 12,
  parameter int CORDIC_STEPS = 16,
  parameter int WRAP_STEPS   = COORD_BITS - 6,
  parameter int WRAP_W       = $clog2(WRAP_STEPS + 1),
  parameter int STEP_W       = $clog2(CORDIC_STEPS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [COORD_BITS-1:0] pointer_x,
  input  logic [COORD_BITS-1:0] pointer_y,
  input  cmd_t                  cmd,
  input  logic [WRAP_W-1:0]     wrap_k,
  input  logic [STEP_W-1:0]     step_idx,
  output logic signed [15:0]    dir_x,
  output logic signed [15:0]    dir_y,
  output logic signed [15:0]    dir_z
);

  localparam int PROD_W = COORD_BITS + 18;
  localparam int ACC_W  = COORD_BITS + 11;
  localparam logic signed [ACC_W-1:0] YAW_BIAS  = ACC_W'(YAW_FULL) << (COORD_BITS - 8);
  localparam logic [ACC_W-1:0]        YAW_FULLW = ACC_W'(YAW_FULL);

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -64'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  logic [15:0]              sensitivity;
  logic [14:0]              pitch_limit;
  logic [COORD_BITS-1:0]    prev_x;
  logic [COORD_BITS-1:0]    prev_y;
  logic                     seen_first;
  logic [16:0]              yaw_angle;
  logic signed [15:0]       pitch_angle;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [PROD_W-1:0] mul_reg;
  logic signed [ACC_W-1:0]  sd_x;
  logic [ACC_W-1:0]         yaw_acc;

  logic signed [32:0]       cx;
  logic signed [32:0]       cy;
  logic signed [29:0]       cz;
  logic                     neg_cos;
  logic signed [31:0]       sp;
  logic signed [31:0]       cp;
  logic signed [63:0]       prod;
  logic signed [15:0]       res_x;

  logic signed [COORD_BITS:0] mul_a;
  logic signed [PROD_W-1:0] mul_res;
  logic signed [PROD_W-1:0] mul_rnd;
  logic signed [ACC_W-1:0]  scaled;
  logic signed [ACC_W-1:0]  yaw_sum;
  logic signed [ACC_W-1:0]  pitch_sum;
  logic signed [ACC_W-1:0]  lim;
  logic signed [15:0]       pitch_clamped;
  logic [ACC_W-1:0]         wrap_const;
  logic signed [17:0]       ang;
  logic signed [17:0]       ang_red;
  logic                     ang_neg;
  logic signed [32:0]       sh_x;
  logic signed [32:0]       sh_y;
  logic signed [29:0]       atan_v;
  logic signed [31:0]       yaw_cos;
  logic signed [31:0]       prod_a;
  logic signed [31:0]       prod_b;
  logic signed [63:0]       rnd_x;
  logic signed [63:0]       rnd_z;
  logic signed [63:0]       rnd_y;

  assign mul_a   = cmd.mul_x ? dx : dy;
  assign mul_res = PROD_W'(mul_a * $signed({1'b0, sensitivity}));
  assign mul_rnd = (mul_reg + PROD_W'(128)) >>> 8;
  assign scaled  = ACC_W'(mul_rnd);

  assign yaw_sum   = $signed({{(ACC_W - 17){1'b0}}, yaw_angle}) + sd_x + YAW_BIAS;
  assign pitch_sum = ACC_W'(pitch_angle) + scaled;
  assign lim       = (pitch_limit > 15'(QUARTER)) ? ACC_W'(QUARTER)
                                                  : $signed({{(ACC_W - 15){1'b0}}, pitch_limit});

  always_comb begin
    if (pitch_sum > lim) begin
      pitch_clamped = 16'(lim);
    end else if (pitch_sum < -lim) begin
      pitch_clamped = 16'(-lim);
    end else begin
      pitch_clamped = 16'(pitch_sum);
    end
  end

  assign wrap_const = YAW_FULLW << wrap_k;

  always_comb begin
    ang     = cmd.init_yaw ? $signed({1'b0, yaw_angle}) : 18'(pitch_angle);
    ang_neg = 1'b0;
    if (ang > 18'sd46080) begin
      ang = ang - 18'sd92160;
    end
    ang_red = ang;
    if (ang > 18'sd23040) begin
      ang_red = 18'sd46080 - ang;
      ang_neg = 1'b1;
    end else if (ang < -18'sd23040) begin
      ang_red = -18'sd46080 - ang;
      ang_neg = 1'b1;
    end
  end

  assign sh_x   = cy >>> step_idx;
  assign sh_y   = cx >>> step_idx;
  assign atan_v = $signed({4'b0, atan_entry(5'(step_idx))});

  assign yaw_cos = neg_cos ? -32'(cx) : 32'(cx);
  assign prod_a  = cp;
  assign prod_b  = cmd.prod_x ? 32'(cy) : yaw_cos;

  assign rnd_x = (prod + 64'sh1000_0000_0000) >>> 45;
  assign rnd_z = (-prod + 64'sh1000_0000_0000) >>> 45;
  assign rnd_y = (64'(sp) + 64'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= SENSITIVITY_RESET;
      pitch_limit <= PITCH_LIMIT_RESET;
      prev_x      <= '0;
      prev_y      <= '0;
      seen_first  <= 1'b0;
      yaw_angle   <= '0;
      pitch_angle <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SENSITIVITY: sensitivity <= cfg_data;
          CFG_PITCH_LIMIT: pitch_limit <= cfg_data[14:0];
          default:         sensitivity <= sensitivity;
        endcase
      end
      if (cmd.load) begin
        prev_x     <= pointer_x;
        prev_y     <= pointer_y;
        seen_first <= 1'b1;
      end
      if (cmd.angle) begin
        pitch_angle <= pitch_clamped;
      end
      if (cmd.yaw_commit) begin
        yaw_angle <= yaw_acc[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (seen_first) begin
        dx <= $signed({1'b0, pointer_x}) - $signed({1'b0, prev_x});
        dy <= $signed({1'b0, prev_y}) - $signed({1'b0, pointer_y});
      end else begin
        dx <= '0;
        dy <= '0;
      end
    end
    if (cmd.mul_x || cmd.mul_y) begin
      mul_reg <= mul_res;
    end
    if (cmd.mul_y) begin
      sd_x <= scaled;
    end
    if (cmd.angle) begin
      yaw_acc <= yaw_sum;
    end
    if (cmd.wrap && (yaw_acc >= wrap_const)) begin
      yaw_acc <= yaw_acc - wrap_const;
    end
    if (cmd.save_pitch) begin
      sp <= 32'(cy);
      cp <= neg_cos ? -32'(cx) : 32'(cx);
    end
    if (cmd.init_pitch || cmd.init_yaw) begin
      cx      <= 33'(CORDIC_GAIN);
      cy      <= '0;
      cz      <= {ang_red, 12'b0};
      neg_cos <= ang_neg;
    end else if (cmd.step) begin
      if (cz >= 0) begin
        cx <= cx - sh_x;
        cy <= cy + sh_y;
        cz <= cz - atan_v;
      end else begin
        cx <= cx + sh_x;
        cy <= cy - sh_y;
        cz <= cz + atan_v;
      end
    end
    if (cmd.prod_x || cmd.prod_z) begin
      prod <= prod_a * prod_b;
    end
    if (cmd.prod_z) begin
      res_x <= sat16(rnd_x);
    end
    if (cmd.out_load) begin
      dir_x <= res_x;
      dir_y <= sat16(rnd_y);
      dir_z <= sat16(rnd_z);
    end
  end

endmodule

// File: rtl/mouse_look_camera_direction_core.sv
// Top level of the mouse-look camera direction core.
// Each pointer transaction updates yaw and pitch from the pointer motion and yields one
// unit view direction in Q1.15; the first transaction after reset seeds the stored
// position and sees no motion. One transaction is worked at a time: after acceptance
// it passes the sensitivity products, the angle update, the yaw wrap, both CORDIC runs
// and the output products before the result register is loaded, and no new transaction
// is accepted until then. The single iterative CORDIC unit runs first for pitch and
// then for yaw; the yaw wrap is COORD_BITS - 6 compare-and-subtract steps. A finished
// result waits in the output register while the next transaction is taken.
module mouse_look_camera_direction_core import mlc_pkg::*; #(
  parameter int COORD_BITS   = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] pointer_x,
  input  logic [COORD_BITS-1:0] pointer_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    dir_x,
  output logic signed [15:0]    dir_y,
  output logic signed [15:0]    dir_z
);

  localparam int WRAP_STEPS = COORD_BITS - 6;
  localparam int WRAP_W     = $clog2(WRAP_STEPS + 1);
  localparam int STEP_W     = $clog2(CORDIC_STEPS);

  cmd_t              cmd;
  logic [WRAP_W-1:0] wrap_k;
  logic [STEP_W-1:0] step_idx;

  mlc_ctrl #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STEPS (CORDIC_STEPS),
    .WRAP_STEPS   (WRAP_STEPS),
    .WRAP_W       (WRAP_W),
    .STEP_W       (STEP_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .wrap_k    (wrap_k),
    .step_idx  (step_idx)
  );

  mlc_datapath #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STEPS (CORDIC_STEPS),
    .WRAP_STEPS   (WRAP_STEPS),
    .WRAP_W       (WRAP_W),
    .STEP_W       (STEP_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pointer_x (pointer_x),
    .pointer_y (pointer_y),
    .cmd       (cmd),
    .wrap_k    (wrap_k),
    .step_idx  (step_idx),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z)
  );

endmodule

// File: tb/sv/tb_mouse_look_camera_direction_core.sv
// Self-checking testbench for the mouse-look camera direction core.
`timescale 1ns / 1ps

module tb_mouse_look_camera_direction_core;
  import mlc_pkg::*;

  localparam int COORD_BITS   = 12;
  localparam int CORDIC_STEPS = 16;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 170;
  localparam int HOLD_CYCLES  = 500;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } direction_t;

  class view_tracker;
    longint sens;
    longint plim;
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;
    bit seeded;
    longint yaw;
    longint pitch;
    longint atan_deg[24];
    direction_t pending_dirs[$];
    int mismatches;
    int checked;

    function new();
      sens = longint'(SENSITIVITY_RESET);
      plim = longint'(PITCH_LIMIT_RESET);
      last_x = '0;
      last_y = '0;
      seeded = 1'b0;
      yaw = 0;
      pitch = 0;
      mismatches = 0;
      checked = 0;
      atan_deg = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                   469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                   917, 458, 229, 115, 57, 29, 14, 7};
    endfunction

    function void set_register(logic idx, logic [15:0] value);
      if (idx == CFG_SENSITIVITY) begin
        sens = longint'(value);
      end else begin
        plim = longint'(value[14:0]);
      end
    endfunction

    function longint scaled(longint d);
      return (d * sens + 128) >>> 8;
    endfunction

    function logic signed [15:0] clip16(longint v);
      if (v > 32767) begin
        return 16'sh7FFF;
      end else if (v < -32768) begin
        return 16'sh8000;
      end
      return v[15:0];
    endfunction

    function void sine_cosine(input longint ang, output longint s, output longint c);
      longint a;
      longint x;
      longint y;
      longint z;
      longint nx;
      longint xs;
      longint ys;
      bit flip;
      a = ang;
      flip = 1'b0;
      if (a > YAW_HALF) a -= YAW_FULL;
      if (a > QUARTER) begin
        a = YAW_HALF - a;
        flip = 1'b1;
      end else if (a < -QUARTER) begin
        a = -YAW_HALF - a;
        flip = 1'b1;
      end
      x = CORDIC_GAIN;
      y = 0;
      z = a * 4096;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        xs = y >>> i;
        ys = x >>> i;
        if (z >= 0) begin
          nx = x - xs;
          y = y + ys;
          z = z - atan_deg[i];
        end else begin
          nx = x + xs;
          y = y - ys;
          z = z + atan_deg[i];
        end
        x = nx;
      end
      s = y;
      c = flip ? -x : x;
    endfunction

    function void take_pointer(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
      longint dx;
      longint dy;
      longint yw;
      longint pt;
      longint lim;
      longint sp;
      longint cp;
      longint syw;
      longint cyw;
      direction_t d;
      if (!seeded) begin
        last_x = px;
        last_y = py;
        seeded = 1'b1;
      end
      dx = longint'(px) - longint'(last_x);
      dy = longint'(last_y) - longint'(py);
      last_x = px;
      last_y = py;
      yw = (yaw + scaled(dx)) % YAW_FULL;
      if (yw < 0) yw += YAW_FULL;
      yaw = yw;
      lim = (plim > QUARTER) ? longint'(QUARTER) : plim;
      pt = pitch + scaled(dy);
      if (pt > lim) pt = lim;
      if (pt < -lim) pt = -lim;
      pitch = pt;
      sine_cosine(pitch, sp, cp);
      sine_cosine(yaw, syw, cyw);
      d.x = clip16((cp * syw + (longint'(1) << 44)) >>> 45);
      d.y = clip16((sp + (longint'(1) << 14)) >>> 15);
      d.z = clip16((-(cp * cyw) + (longint'(1) << 44)) >>> 45);
      pending_dirs.push_back(d);
    endfunction

    function void check_direction(logic signed [15:0] ax, logic signed [15:0] ay,
                                  logic signed [15:0] az);
      direction_t e;
      if (pending_dirs.size() == 0) begin
        $error("dir: result arrived with no transaction outstanding");
        mismatches++;
        return;
      end
      e = pending_dirs.pop_front();
      checked++;
      if (ax !== e.x) begin
        $error("dir_x: expected %0d, got %0d", e.x, ax);
        mismatches++;
      end
      if (ay !== e.y) begin
        $error("dir_y: expected %0d, got %0d", e.y, ay);
        mismatches++;
      end
      if (az !== e.z) begin
        $error("dir_z: expected %0d, got %0d", e.z, az);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COORD_BITS-1:0] pointer_x = '0;
  logic [COORD_BITS-1:0] pointer_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;

  view_tracker tracker = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int settings_applied = 0;
  int sent = 0;
  logic [COORD_BITS-1:0] cur_x = '0;
  logic [COORD_BITS-1:0] cur_y = '0;

  mouse_look_camera_direction_core #(
    .COORD_BITS  (COORD_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .pointer_x(pointer_x),
    .pointer_y(pointer_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // The receiver stalls at random, and on request holds off for a long stretch.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
        holds_served++;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_direction(dir_x, dir_y, dir_z);
    end
  end

  task automatic send_pointer(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    pointer_x <= px;
    pointer_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_pointer(px, py);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_dirs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    tracker.set_register(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [15:0] sens_value, logic [15:0] limit_value);
    drain();
    write_register(CFG_SENSITIVITY, sens_value);
    write_register(CFG_PITCH_LIMIT, limit_value);
    settings_applied++;
  endtask

  function automatic logic [COORD_BITS-1:0] walk(logic [COORD_BITS-1:0] pos);
    int sel;
    int step;
    int next;
    sel = $urandom_range(99);
    if (sel < 10) return COORD_BITS'($urandom);
    step = (sel < 75) ? 40 : 600;
    next = int'(pos) + $urandom_range(2 * step) - step;
    if (next < 0) next = 0;
    if (next > 4095) next = 4095;
    return COORD_BITS'(next);
  endfunction

  initial begin : stimulus
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_pointer(12'd2048, 12'd2048);
    send_pointer(12'd2048, 12'd2048);
    send_pointer(12'd4095, 12'd2048);
    send_pointer(12'd0, 12'd2048);
    send_pointer(12'd4095, 12'd2048);
    send_pointer(12'd4095, 12'd0);
    send_pointer(12'd4095, 12'd4095);
    send_pointer(12'd4095, 12'd0);
    send_pointer(12'd0, 12'd4095);
    send_pointer(12'd0, 12'd0);

    apply_setting(16'hFFFF, 16'hFFFF);
    send_pointer(12'd4095, 12'd4095);
    send_pointer(12'd0, 12'd0);
    send_pointer(12'd4095, 12'd0);
    send_pointer(12'd0, 12'd4095);
    send_pointer(12'd2000, 12'd2000);
    send_pointer(12'd2001, 12'd1999);

    apply_setting(16'd0, 16'd0);
    send_pointer(12'd123, 12'd456);
    send_pointer(12'd4095, 12'd0);
    send_pointer(12'd0, 12'd4095);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_setting(SENSITIVITY_RESET, 16'(PITCH_LIMIT_RESET));
        1: apply_setting(16'hFFFF, 16'(QUARTER));
        3: apply_setting(16'd200, 16'd11520);
        4: apply_setting(16'd0, 16'd0);
        5: apply_setting(16'd1, 16'(QUARTER + 1));
        6: apply_setting(16'd12000, 16'd5000);
        8: apply_setting(SENSITIVITY_RESET, 16'(PITCH_LIMIT_RESET));
        default: apply_setting(16'($urandom), 16'($urandom));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 82; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 82; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 20 && (p == 0 || p == 6)) hold_requests++;
        cur_x = walk(cur_x);
        cur_y = walk(cur_y);
        send_pointer(cur_x, cur_y);
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("Checked %0d view directions from %0d pointer transactions", tracker.checked,
             sent);
    $display("over %0d register settings, four idle patterns and %0d long output holds.",
             settings_applied + 1, holds_served);
    if (tracker.mismatches == 0 && tracker.pending_dirs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
